### design/quintic_joint_trajectory_generator_assert.svh
// Assertion macros used by the checker of this block.
`ifndef QUINTIC_JOINT_TRAJECTORY_GENERATOR_ASSERT_SVH
`define QUINTIC_JOINT_TRAJECTORY_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define QJTG_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qjtg assertion failed");

// Next-cycle implication, disabled during reset.
`define QJTG_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qjtg assertion failed");

`endif

### design/qjtg_pkg.sv
`default_nettype none
package qjtg_pkg;

  // Geometry and number formats.
  localparam int JOINTS_DEF = 6;
  localparam int POS_W      = 24;
  localparam int CFG_W      = 16;
  localparam int UQ         = 30;
  localparam int MUL_W      = 33;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int DIVD_W     = 48;
  localparam int DIVS_W     = 36;
  localparam int QUO_W      = 30;
  localparam int QBITS_W    = 5;
  localparam int VEL_QBITS  = 24;
  localparam int VEL_SCALE  = 1000000;

  localparam logic [CFG_W-1:0] DUR_RESET = 16'd2000;
  localparam logic [CFG_W-1:0] PER_RESET = 16'd2000;

  // Input command codes.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Register indexes.
  localparam logic REG_DURATION = 1'b0;
  localparam logic REG_PERIOD   = 1'b1;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIVU,
    ST_U2,
    ST_U3,
    ST_U4,
    ST_U5,
    ST_DEN,
    ST_SG,
    ST_JPOS,
    ST_JVEL,
    ST_JNUM,
    ST_JDIV0,
    ST_JDIV,
    ST_OUT
  } state_t;

  // Request to the shared divider.
  typedef struct packed {
    logic               start;
    logic [DIVD_W-1:0]  dividend;
    logic [DIVS_W-1:0]  divisor;
    logic [QBITS_W-1:0] qbits;
  } div_req_t;

  // Answer from the shared divider.
  typedef struct packed {
    logic             done;
    logic             ovf;
    logic [QUO_W-1:0] quot;
  } div_rsp_t;

endpackage
`default_nettype wire

### design/qjtg_if.sv
`default_nettype none
// Command request channel.
interface qjtg_in_if import qjtg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [2:0]       joint_index;
  logic [POS_W-1:0] start_pos;
  logic [POS_W-1:0] end_pos;

  modport source (output valid, cmd, joint_index, start_pos, end_pos, input ready);
  modport sink (input valid, cmd, joint_index, start_pos, end_pos, output ready);
endinterface

// Sample output channel.
interface qjtg_out_if import qjtg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [2:0]       joint_id;
  logic [POS_W-1:0] position;
  logic [POS_W-1:0] velocity;
  logic             last_joint;
  logic             final_sample;

  modport source (output valid, joint_id, position, velocity, last_joint, final_sample,
                  input ready);
  modport sink (input valid, joint_id, position, velocity, last_joint, final_sample,
                output ready);
endinterface
`default_nettype wire

### design/quintic_joint_trajectory_generator.sv
`default_nettype none
// Quintic minimum-jerk trajectory generator for JOINTS joints. A load request
// (cmd 0) stores one joint's start and end position and restarts the sample
// index; a tick request (cmd 1) returns one sample per joint, in joint order,
// for index k = 0 .. N-1 and then nothing until the next load. A tick keeps
// the block busy from its acceptance to the next possible acceptance, and
// longer while a sample waits: the accepting cycle, a 30-step division for
// u = k/N, shared multiplies for the powers of u, N*dt and the blend sums,
// then per joint multiplies and divider setup, a 24-step division for the
// velocity and an output step, all run on one multiplier and one bit-serial
// divider under a small sequencer. The block takes no request while a tick
// is in progress. Registers sit on an APB port: duration_ticks at 0x0 and
// tick_period_us at 0x4.
module quintic_joint_trajectory_generator import qjtg_pkg::*; #(
  parameter int JOINTS = JOINTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  qjtg_in_if.sink          in_chan,
  qjtg_out_if.source       out_chan,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

  state_t state, state_next;

  logic [CFG_W-1:0] dur;
  logic [CFG_W-1:0] per;
  logic [CFG_W-1:0] per_eff;
  logic [CFG_W-1:0] sample_count;

  logic [POS_W-1:0] start_mem [JOINTS];
  logic [POS_W-1:0] end_mem   [JOINTS];

  logic [JW-1:0]    jcnt;
  logic [UQ-1:0]    u, u2, u3, u4, u5;
  logic signed [MUL_W-1:0] s, g;
  logic [DIVS_W-1:0] den;
  logic             neg;
  logic [POS_W-1:0] pos_r;

  logic             out_valid;
  logic [2:0]       out_joint;
  logic [POS_W-1:0] out_pos;
  logic [POS_W-1:0] out_vel;
  logic             out_last;
  logic             out_final;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] p;
  div_req_t                 dreq;
  div_rsp_t                 drsp;

  logic in_fire, out_fire, cfg_wr, is_last, load_ok, tick_go;
  logic signed [POS_W:0]    delta;
  logic signed [PROD_W-1:0] rnd;
  logic signed [27:0]       rsh;
  logic signed [28:0]       pos_sum;
  logic [PROD_W-1:0]        mag_full;
  logic signed [UQ+3:0]     s_full, g_full;
  logic [POS_W-1:0]         vel_v;

  qjtg_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(p));
  qjtg_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // Handshake and configuration decode.
  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_fire = out_valid && out_chan.ready;
  assign cfg_wr   = psel && penable && pwrite;
  assign pready   = 1'b1;
  assign per_eff  = (per == '0) ? CFG_W'(1) : per;
  assign is_last  = (jcnt == JW'(JOINTS - 1));
  assign load_ok  = (32'(in_chan.joint_index) < JOINTS);
  assign tick_go  = (sample_count < dur);

  // Register read-back.
  always_comb begin
    case (paddr[2])
      REG_DURATION: prdata = {16'b0, dur};
      REG_PERIOD:   prdata = {16'b0, per};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dur <= DUR_RESET;
      per <= PER_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_DURATION: dur <= pwdata[CFG_W-1:0];
        REG_PERIOD:   per <= pwdata[CFG_W-1:0];
        default:      dur <= dur;
      endcase
    end
  end

  // Per-joint helpers from the registered product.
  assign delta    = $signed({end_mem[jcnt][POS_W-1], end_mem[jcnt]})
                  - $signed({start_mem[jcnt][POS_W-1], start_mem[jcnt]});
  assign rnd      = p + (PROD_W'(1) <<< (UQ - 1));
  assign rsh      = rnd[UQ+27:UQ];
  assign pos_sum  = $signed({{5{start_mem[jcnt][POS_W-1]}}, start_mem[jcnt]})
                  + $signed({rsh[27], rsh});
  assign mag_full = neg ? PROD_W'(-p) : PROD_W'(p);

  // Blend polynomials in Q30 from the stored powers.
  assign s_full = $signed({4'b0, u3} * 10) - $signed({4'b0, u4} * 15)
                + $signed({4'b0, u5} * 6);
  assign g_full = $signed({4'b0, u2} * 30) - $signed({4'b0, u3} * 60)
                + $signed({4'b0, u4} * 30);

  // Velocity saturation from the divider's quotient.
  always_comb begin
    if (!neg) begin
      vel_v = (drsp.ovf || drsp.quot[VEL_QBITS-1]) ? {1'b0, {(POS_W-1){1'b1}}}
                                                  : {1'b0, drsp.quot[POS_W-2:0]};
    end else begin
      vel_v = (drsp.ovf || drsp.quot[VEL_QBITS-1]) ? {1'b1, {(POS_W-1){1'b0}}}
                                                  : POS_W'(-{1'b0, drsp.quot[POS_W-2:0]});
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_fire && in_chan.cmd == CMD_TICK && tick_go) state_next = ST_DIVU;
      ST_DIVU:  if (drsp.done) state_next = ST_U2;
      ST_U2:    state_next = ST_U3;
      ST_U3:    state_next = ST_U4;
      ST_U4:    state_next = ST_U5;
      ST_U5:    state_next = ST_DEN;
      ST_DEN:   state_next = ST_SG;
      ST_SG:    state_next = ST_JPOS;
      ST_JPOS:  state_next = ST_JVEL;
      ST_JVEL:  state_next = ST_JNUM;
      ST_JNUM:  state_next = ST_JDIV0;
      ST_JDIV0: state_next = ST_JDIV;
      ST_JDIV:  if (drsp.done) state_next = ST_OUT;
      ST_OUT:   if (out_fire) state_next = is_last ? ST_IDLE : ST_JPOS;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Unit operands and request ready.
  always_comb begin
    mul_a         = '0;
    mul_b         = '0;
    dreq.start    = 1'b0;
    dreq.dividend = '0;
    dreq.divisor  = '0;
    dreq.qbits    = '0;
    in_chan.ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_chan.valid && in_chan.cmd == CMD_TICK && tick_go) begin
          dreq.start    = 1'b1;
          dreq.dividend = {2'b0, sample_count, {UQ{1'b0}}};
          dreq.divisor  = {{(DIVS_W-CFG_W){1'b0}}, dur};
          dreq.qbits    = QBITS_W'(UQ);
        end
      end
      ST_U2: begin
        mul_a = {3'b0, u};
        mul_b = {3'b0, u};
      end
      ST_U3, ST_U4, ST_U5: begin
        mul_a = {3'b0, p[2*UQ-1:UQ]};
        mul_b = {3'b0, u};
      end
      ST_DEN: begin
        mul_a = {{(MUL_W-CFG_W){1'b0}}, dur};
        mul_b = {{(MUL_W-CFG_W){1'b0}}, per_eff};
      end
      ST_JPOS: begin
        mul_a = {{(MUL_W-POS_W-1){delta[POS_W]}}, delta};
        mul_b = s;
      end
      ST_JVEL: begin
        mul_a = {{(MUL_W-POS_W-1){delta[POS_W]}}, delta};
        mul_b = g;
      end
      ST_JNUM: begin
        mul_a = {{(MUL_W-28){rsh[27]}}, rsh};
        mul_b = MUL_W'(VEL_SCALE);
      end
      ST_JDIV0: begin
        dreq.start    = 1'b1;
        dreq.dividend = {1'b0, mag_full[DIVD_W-2:0]}
                      + {{(DIVD_W-DIVS_W+1){1'b0}}, den[DIVS_W-1:1]};
        dreq.divisor  = den;
        dreq.qbits    = QBITS_W'(VEL_QBITS);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  // Sequencer and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      sample_count <= '0;
      jcnt         <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && in_fire && in_chan.cmd == CMD_LOAD && load_ok) begin
        sample_count <= '0;
      end
      if (state == ST_SG) begin
        jcnt <= '0;
      end
      if (state == ST_JDIV && drsp.done) begin
        out_valid <= 1'b1;
      end
      if (out_fire) begin
        out_valid <= 1'b0;
        if (is_last) begin
          sample_count <= sample_count + CFG_W'(1);
        end else begin
          jcnt <= jcnt + JW'(1);
        end
      end
    end
  end

  // Endpoint stores, cleared at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < JOINTS; i++) begin
        start_mem[i] <= '0;
        end_mem[i]   <= '0;
      end
    end else if (state == ST_IDLE && in_fire && in_chan.cmd == CMD_LOAD && load_ok) begin
      start_mem[JW'(in_chan.joint_index)] <= in_chan.start_pos;
      end_mem[JW'(in_chan.joint_index)]   <= in_chan.end_pos;
    end
  end

  // Working registers of the datapath.
  always_ff @(posedge clk) begin
    case (state)
      ST_DIVU:  if (drsp.done) u <= drsp.quot;
      ST_U3:    u2 <= p[2*UQ-1:UQ];
      ST_U4:    u3 <= p[2*UQ-1:UQ];
      ST_U5:    u4 <= p[2*UQ-1:UQ];
      ST_DEN:   u5 <= p[2*UQ-1:UQ];
      ST_SG: begin
        den <= {p[31:0], 4'b0};
        s   <= s_full[MUL_W-1:0];
        g   <= g_full[MUL_W-1:0];
      end
      // The position product is on the multiplier output here.
      ST_JVEL: begin
        if (pos_sum[28:23] != {6{pos_sum[28]}}) begin
          pos_r <= pos_sum[28] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end else begin
          pos_r <= pos_sum[POS_W-1:0];
        end
      end
      ST_JNUM: begin
        neg <= rsh[27];
      end
      ST_JDIV: begin
        if (drsp.done) begin
          out_joint <= 3'(jcnt);
          out_pos   <= pos_r;
          out_vel   <= vel_v;
          out_last  <= is_last;
          out_final <= ({1'b0, sample_count} + 17'd1) == {1'b0, dur};
        end
      end
      default: begin
        den <= den;
      end
    endcase
  end

  assign out_chan.valid        = out_valid;
  assign out_chan.joint_id     = out_joint;
  assign out_chan.position     = out_pos;
  assign out_chan.velocity     = out_vel;
  assign out_chan.last_joint   = out_last;
  assign out_chan.final_sample = out_final;

endmodule
`default_nettype wire

### design/qjtg_mul.sv
`default_nettype none
module qjtg_mul import qjtg_pkg::*; (
  input  wire logic                     clk,
  input  wire logic signed [MUL_W-1:0]  a,
  input  wire logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0]      p
);

  // Shared signed multiplier with its product registered.
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule
`default_nettype wire

### design/qjtg_div.sv
`default_nettype none
module qjtg_div import qjtg_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire div_req_t req,
  output div_rsp_t rsp
);

  localparam int DSR_W = PROD_W;

  logic [DIVD_W-1:0]  rem;
  logic [DSR_W-1:0]   dsr;
  logic [QUO_W-1:0]   q;
  logic [QBITS_W-1:0] cnt;
  logic               busy;
  logic               done;
  logic               ovf;
  logic               ge;
  logic [DIVD_W-1:0]  rem_next;

  // One restoring step: compare the remainder with the shifted divisor.
  assign ge       = {{(DSR_W-DIVD_W){1'b0}}, rem} >= dsr;
  assign rem_next = ge ? (rem - dsr[DIVD_W-1:0]) : rem;

  // Iterate one quotient bit per cycle, most significant first.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.qbits - QBITS_W'(1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - QBITS_W'(1);
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.dividend;
      dsr <= {{(DSR_W-DIVS_W){1'b0}}, req.divisor} << (req.qbits - QBITS_W'(1));
      ovf <= {{(DSR_W-DIVD_W){1'b0}}, req.dividend}
             >= ({{(DSR_W-DIVS_W){1'b0}}, req.divisor} << req.qbits);
      q   <= '0;
    end else if (busy) begin
      rem <= rem_next;
      dsr <= dsr >> 1;
      q   <= {q[QUO_W-2:0], ge};
    end
  end

  assign rsp.done = done;
  assign rsp.ovf  = ovf;
  assign rsp.quot = q;

endmodule
`default_nettype wire

### design/qjtg_checker.sv
`default_nettype none
`include "quintic_joint_trajectory_generator_assert.svh"
module qjtg_checker import qjtg_pkg::*; #(
  parameter int JOINTS = JOINTS_DEF
) (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       last_joint,
  input wire logic [2:0] joint_id,
  input wire logic       pready
);

  // No new request is taken while a sample waits.
  `QJTG_ASSERT_IMPL(a_no_in_with_out, clk, rst, out_valid, !in_ready)
  // A waiting sample stays offered.
  `QJTG_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  // The last sample of a tick belongs to the highest joint.
  `QJTG_ASSERT_IMPL(a_last_id, clk, rst, out_valid && last_joint, joint_id == 3'(JOINTS - 1))
  // Once a non-final sample of a tick is taken the block is still busy.
  `QJTG_ASSERT_NEXT(a_busy_mid_tick, clk, rst, out_valid && out_ready && !last_joint,
                    !in_ready)
  // The register port never waits.
  `QJTG_ASSERT_IMPL(a_pready, clk, rst, in_valid || !in_valid, pready)

endmodule

bind quintic_joint_trajectory_generator qjtg_checker #(.JOINTS(JOINTS)) u_qjtg_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .last_joint (out_chan.last_joint),
  .joint_id   (out_chan.joint_id),
  .pready     (pready)
);
`default_nettype wire
